// ===== rtl/gbf_pkg.sv =====
`timescale 1ns / 1ps

package gbf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WREG_W      = 11;
  localparam int HREG_W      = 13;
  localparam int PIX_W       = 8;
  localparam int WINDOW      = 5;
  localparam int LINE_W      = PIX_W * (WINDOW - 1);
  localparam int CSUM_W      = 11;
  localparam int WSUM_W      = 13;
  localparam int GSUM_W      = 24;
  localparam int PROD_W      = 2 * WSUM_W;
  localparam int MIN_DIM     = 5;
  localparam int BORDER      = 2;
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GSUM_W-1:0] GRAY_R_COEF = 24'd13763;
  localparam logic [GSUM_W-1:0] GRAY_G_COEF = 24'd46530;
  localparam logic [GSUM_W-1:0] GRAY_B_COEF = 24'd4588;

  // floor(s / 25) == (s * 5243) >> 17 for every window sum s
  localparam logic [PROD_W-1:0] MEAN_RECIP = 26'd5243;
  localparam int                MEAN_SHIFT = 17;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [PIX_W-1:0] gray;
    logic             win;
    logic             bord;
    logic             last;
  } pix_ctrl_t;

  typedef struct packed {
    pix_ctrl_t        ctrl;
    logic [PIX_W-1:0] mean;
  } res_rec_t;

endpackage

// ===== rtl/gbf_if.sv =====
`timescale 1ns / 1ps

interface gbf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface gbf_result_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  gray_value;
  logic        last_of_run;

  modport source (output valid, output pixel_x, output pixel_y, output gray_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input gray_value,
                  input last_of_run, output ready);
endinterface

// ===== rtl/gbf_cell.sv =====
`timescale 1ns / 1ps

module gbf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [gbf_pkg::CSUM_W-1:0] sum_in,
  output logic [gbf_pkg::CSUM_W-1:0] sum_out
);
  import gbf_pkg::*;

  // one window column, held as its gray sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= '0;
    end else if (shift) begin
      sum_out <= sum_in;
    end
  end

endmodule

// ===== rtl/gbf_result_queue.sv =====
`timescale 1ns / 1ps

module gbf_result_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  gbf_pkg::res_rec_t         push_rec,
  output logic [gbf_pkg::CNT_W-1:0] count,
  gbf_result_if.source              result
);
  import gbf_pkg::*;

  res_rec_t         entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             sent_win;
  res_rec_t         head;
  logic             send_win;
  logic             fire;
  logic             pop;

  assign head     = entry[rd_ptr];
  assign fire     = result.valid && result.ready;
  assign send_win = head.ctrl.win && !sent_win;
  // a record with both results leaves after its second beat
  assign pop      = fire && !(send_win && head.ctrl.bord);

  always_comb begin
    result.valid = (count != '0);
    if (send_win) begin
      result.pixel_x     = head.ctrl.x - COL_W'(BORDER);
      result.pixel_y     = head.ctrl.y - ROW_W'(BORDER);
      result.gray_value  = head.mean;
      result.last_of_run = 1'b0;
    end else begin
      result.pixel_x     = head.ctrl.x;
      result.pixel_y     = head.ctrl.y;
      result.gray_value  = head.ctrl.gray;
      result.last_of_run = head.ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      sent_win <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
      if (pop) begin
        sent_win <= 1'b0;
      end else if (fire) begin
        sent_win <= 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(QUEUE_DEPTH)))
    else $error("result queue written while full");

  a_half_sent: assert property (@(posedge clk) disable iff (rst)
    sent_win |-> (count != '0) && head.ctrl.win && head.ctrl.bord)
    else $error("window beat marked sent on a record without a border beat");

endmodule

// ===== rtl/gray_box_filter_5x5.sv =====
`timescale 1ns / 1ps
// Order: a pixel's results pass registers v1 to v4 into the result queue, then the result channel;
//   a pixel with a window mean and a border result gives them in two consecutive beats.
// Throughput: one pixel per cycle; in the last two rows most pixels give two beats on the
//   single result port, so intake drops to about half rate there. An 8-entry result queue,
//   credited against the 4-stage pipeline, sets the stall point.
// Reset (synchronous, active high): counters, window cells, queue and pipeline cleared,
//   size registers to 640 x 480; the line store is not cleared and needs no pass.
module gray_box_filter_5x5 (
  input  logic        clk,
  input  logic        rst,
  gbf_pixel_if.sink   pixel,
  gbf_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gbf_pkg::*;

  logic [WREG_W-1:0] image_width;
  logic [HREG_W-1:0] image_height;
  logic [WREG_W-1:0] w;
  logic [HREG_W-1:0] h;
  logic              cfg_write;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              in_fire;
  logic              last_col;
  logic              last_row;
  logic [GSUM_W-1:0] gray_sum;
  pix_ctrl_t         c0;

  logic [LINE_W-1:0] line_store [MAX_WIDTH];
  logic [LINE_W-1:0] mem_rd;

  logic              v1, v2, v3, v4;
  pix_ctrl_t         c1, c2, c3, c4;
  logic [CSUM_W-1:0] cs2;
  logic [CSUM_W-1:0] cell_sum [WINDOW];
  logic [WSUM_W-1:0] win_sum;
  logic [WSUM_W-1:0] wsum4;
  logic [PROD_W-1:0] prod;

  logic              push;
  res_rec_t          push_rec;
  logic [CNT_W-1:0]  count;
  logic [CNT_W:0]    pending;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WREG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < WREG_W'(MIN_DIM)) begin
      w = WREG_W'(MIN_DIM);
    end else if (image_width > WREG_W'(MAX_WIDTH)) begin
      w = WREG_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height < HREG_W'(MIN_DIM)) begin
      h = HREG_W'(MIN_DIM);
    end else if (image_height > HREG_W'(MAX_HEIGHT)) begin
      h = HREG_W'(MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  // intake: gray conversion and position
  assign pending     = {1'b0, count} + (CNT_W+1)'(v1) + (CNT_W+1)'(v2)
                     + (CNT_W+1)'(v3) + (CNT_W+1)'(v4);
  assign pixel.ready = (pending < (CNT_W+1)'(QUEUE_DEPTH));
  assign in_fire     = pixel.valid && pixel.ready;

  // the sum stays below 2^24, so the top byte is already clamped to 255
  assign gray_sum = GSUM_W'(pixel.red) * GRAY_R_COEF + GSUM_W'(pixel.green) * GRAY_G_COEF
                  + GSUM_W'(pixel.blue) * GRAY_B_COEF;

  assign last_col = (WREG_W'(column_count) >= w - WREG_W'(1));
  assign last_row = (HREG_W'(row_count) >= h - HREG_W'(1));

  always_comb begin
    c0.x    = column_count;
    c0.y    = row_count;
    c0.gray = gray_sum[GSUM_W-1 -: PIX_W];
    c0.win  = (column_count >= COL_W'(WINDOW - 1)) && (row_count >= ROW_W'(WINDOW - 1));
    c0.bord = (column_count < COL_W'(BORDER)) || (row_count < ROW_W'(BORDER))
           || (WREG_W'(column_count) >= w - WREG_W'(BORDER))
           || (HREG_W'(row_count) >= h - HREG_W'(BORDER));
    c0.last = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // line store: per column, grays of the four rows above
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd <= line_store[column_count];
    end
    if (v1) begin
      line_store[c1.x] <= {mem_rd[LINE_W-PIX_W-1:0], c1.gray};
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    c1    <= c0;
    c2    <= c1;
    c3    <= c2;
    c4    <= c3;
    cs2   <= CSUM_W'(mem_rd[31:24]) + CSUM_W'(mem_rd[23:16]) + CSUM_W'(mem_rd[15:8])
           + CSUM_W'(mem_rd[7:0]) + CSUM_W'(c1.gray);
    wsum4 <= win_sum;
  end

  // window: chain of column cells
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      gbf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (v2),
        .sum_in  (cs2),
        .sum_out (cell_sum[i])
      );
    end else begin : g_link
      gbf_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (v2),
        .sum_in  (cell_sum[i-1]),
        .sum_out (cell_sum[i])
      );
    end
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      win_sum = win_sum + WSUM_W'(cell_sum[i]);
    end
  end

  // mean by reciprocal, then into the result queue
  assign prod          = PROD_W'(wsum4) * MEAN_RECIP;
  assign push          = v4 && (c4.win || c4.bord);
  assign push_rec.ctrl = c4;
  assign push_rec.mean = prod[MEAN_SHIFT +: PIX_W];

  gbf_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .count    (count),
    .result   (result)
  );

  a_credit: assert property (@(posedge clk) disable iff (rst)
    pending <= (CNT_W+1)'(QUEUE_DEPTH))
    else $error("more pixels in flight than queue space");

  a_line_hazard: assert property (@(posedge clk) disable iff (rst)
    (in_fire && v1) |-> (column_count != c1.x))
    else $error("line store read and written at one column");

  a_mean_only_inside: assert property (@(posedge clk) disable iff (rst)
    (v4 && c4.win) |-> (c4.x >= COL_W'(WINDOW - 1)) && (c4.y >= ROW_W'(WINDOW - 1)))
    else $error("window mean for a pixel outside the interior");

endmodule

// ===== bench/gbf_checker.sv =====
`timescale 1ns / 1ps

module gbf_checker (
  input  logic        clk,
  input  logic        rst,
  gbf_pixel_if        pixel,
  gbf_result_if       result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int          fail_count,
  output int          pending
);
  import gbf_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [PIX_W-1:0] gray;
    logic             last;
  } out_pix_t;

  out_pix_t          expected_pix[$];
  out_pix_t          want;
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  cells [WINDOW][WINDOW];
  int unsigned       col_pos;
  int unsigned       row_pos;

  initial fail_count = 0;

  function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_state();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) line_mem[i] = '0;
    for (int i = 0; i < WINDOW; i++)
      for (int j = 0; j < WINDOW; j++) cells[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    expected_pix.delete();
  endtask

  // one pixel in, up to two output pixels queued: window mean first, then border
  task automatic filter_pixel(input logic [7:0] red_v, input logic [7:0] green_v,
                              input logic [7:0] blue_v);
    int unsigned       w;
    int unsigned       h;
    int unsigned       x;
    int unsigned       y;
    int unsigned       gray;
    int unsigned       wsum;
    logic [LINE_W-1:0] above;
    logic [PIX_W-1:0]  column [WINDOW];
    out_pix_t          res;
    w = saturate(32'(width_reg), 5, 1024);
    h = saturate(32'(height_reg), 5, 4096);
    x = col_pos;
    y = row_pos;
    gray = (13763 * red_v + 46530 * green_v + 4588 * blue_v) >> 16;
    if (gray > 255) gray = 255;
    above = line_mem[x];
    column[0] = above[31:24];
    column[1] = above[23:16];
    column[2] = above[15:8];
    column[3] = above[7:0];
    column[4] = gray[7:0];
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW - 1; j++) cells[i][j] = cells[i][j+1];
      cells[i][WINDOW-1] = column[i];
    end
    line_mem[x] = {above[23:0], gray[7:0]};

    if (x >= 4 && y >= 4) begin
      wsum = 0;
      for (int i = 0; i < WINDOW; i++)
        for (int j = 0; j < WINDOW; j++) wsum += cells[i][j];
      res.x    = COL_W'(x - 2);
      res.y    = ROW_W'(y - 2);
      res.gray = PIX_W'(wsum / 25);
      res.last = 1'b0;
      expected_pix.push_back(res);
    end

    if (x < 2 || y < 2 || x >= w - 2 || y >= h - 2) begin
      res.x    = COL_W'(x);
      res.y    = ROW_W'(y);
      res.gray = gray[7:0];
      res.last = (x >= w - 1) && (y >= h - 1);
      expected_pix.push_back(res);
    end

    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      pending <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_pix.size() == 0) begin
          $error("unexpected result beat: pixel_x %0d pixel_y %0d gray_value %0d",
                 result.pixel_x, result.pixel_y, result.gray_value);
          fail_count++;
        end else begin
          want = expected_pix.pop_front();
          if (result.pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, actual %0d", want.x, result.pixel_x);
            fail_count++;
          end
          if (result.pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, actual %0d", want.y, result.pixel_y);
            fail_count++;
          end
          if (result.gray_value !== want.gray) begin
            $error("gray_value: expected %0d, actual %0d", want.gray, result.gray_value);
            fail_count++;
          end
          if (result.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, result.last_of_run);
            fail_count++;
          end
        end
      end

      if (pixel.valid && pixel.ready)
        filter_pixel(pixel.red, pixel.green, pixel.blue);

      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_IMAGE_HEIGHT) height_reg = pwdata[HREG_W-1:0];
          else width_reg = pwdata[WREG_W-1:0];
        end else if (paddr[2] == REG_IMAGE_HEIGHT) begin
          if (prdata[HREG_W-1:0] !== height_reg) begin
            $error("image_height: expected %0d, actual %0d", height_reg,
                   prdata[HREG_W-1:0]);
            fail_count++;
          end
        end else if (prdata[WREG_W-1:0] !== width_reg) begin
          $error("image_width: expected %0d, actual %0d", width_reg, prdata[WREG_W-1:0]);
          fail_count++;
        end
      end

      pending <= expected_pix.size();
    end
  end

endmodule

// ===== bench/tb_gray_box_filter_5x5.sv =====
`timescale 1ns / 1ps

module tb_gray_box_filter_5x5;
  import gbf_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 12;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left = 0;
  int rand_sent;
  int w_raw;
  int h_raw;
  int w_eff;
  int h_eff;
  bit phase3_hold_done;

  logic [23:0] corner_rgb [7] = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                                  24'h0000ff, 24'haa55aa, 24'h55aa55};

  gbf_pixel_if  pixel_ch ();
  gbf_result_if result_ch ();

  gray_box_filter_5x5 i_dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gbf_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic int clamp_dim(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic send_pixel(input logic [23:0] rgb);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red   <= rgb[23:16];
    pixel_ch.green <= rgb[15:8];
    pixel_ch.blue  <= rgb[7:0];
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  task automatic random_pixel();
    logic [23:0] rgb;
    rgb = 24'($urandom);
    if ($urandom_range(9) == 0)
      for (int k = 0; k < 3; k++) rgb[8*k +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
    send_pixel(rgb);
  endtask

  // block idle: every beat out, then a SETTLE wait for items that give nothing
  task automatic drain();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic is_write, input logic reg_index,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_and_check(input logic reg_index, input logic [31:0] data);
    apb_access(1'b1, reg_index, data);
    apb_access(1'b0, reg_index, '0);
  endtask

  task automatic set_geometry(input int wr, input int hr);
    drain();
    write_and_check(REG_IMAGE_WIDTH, wr);
    write_and_check(REG_IMAGE_HEIGHT, hr);
  endtask

  initial begin
    rst             = 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red   <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue  <= '0;
    src_idle_pct    = 9;
    snk_idle_pct   <= 64;
    phase3_hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry, then width cut mid-row and height cut mid-image
    repeat (23) random_pixel();
    drain();
    write_and_check(REG_IMAGE_WIDTH, 5);
    repeat (1 + 7 * 5) random_pixel();
    drain();
    write_and_check(REG_IMAGE_HEIGHT, 3);
    repeat (5) random_pixel();

    // smallest image, width below range, colour extremes
    set_geometry(0, 5);
    for (int i = 0; i < 25; i++) begin
      if (i < 7) send_pixel(corner_rgb[i]);
      else random_pixel();
    end

    // both dimensions above range, then both cut mid-image
    set_geometry(2047, 8191);
    repeat (16 + 7) random_pixel();
    drain();
    write_and_check(REG_IMAGE_WIDTH, 6);
    repeat (1 + 4 * 6) random_pixel();
    drain();
    write_and_check(REG_IMAGE_HEIGHT, 6);
    repeat (6) random_pixel();

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent >= 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        snk_idle_pct <= 0;
      end else if (rand_sent >= RANDOM_ITEMS / 3) begin
        src_idle_pct  = 64;
        snk_idle_pct <= 9;
      end
      w_raw = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 14);
      h_raw = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 9);
      w_eff = clamp_dim(w_raw, MIN_DIM, MAX_WIDTH);
      h_eff = clamp_dim(h_raw, MIN_DIM, MAX_HEIGHT);
      set_geometry(w_raw, h_raw);
      if (rand_sent == 0 && hold_left == 0) hold_left <= LONG_HOLD;
      if (rand_sent >= 2 * RANDOM_ITEMS / 3 && !phase3_hold_done && hold_left == 0) begin
        hold_left <= LONG_HOLD;
        phase3_hold_done = 1'b1;
      end
      repeat (w_eff * h_eff) random_pixel();
      rand_sent += w_eff * h_eff;
    end

    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
